// ----- hdl/binary_to_decimal_ascii_top_assert.svh -----
// Assertion macros shared by the converter RTL.
// Each check is sampled on the rising edge of aclk and is off while aresetn is low.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication.
`define B2DA_ASSERT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define B2DA_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/b2da_pkg.sv -----
package b2da_pkg;

    // Width of the binary input value.
    localparam int VALUE_WIDTH = 16;

    // Decimal digits needed for the largest value: floor(W * log10(2)) + 1.
    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    // Division by ten as a multiplication by a rounded-up reciprocal.
    // Four extra fraction bits keep the quotient exact over the whole range.
    localparam int RECIP_SHIFT = VALUE_WIDTH + 4;
    localparam int RECIP_W     = VALUE_WIDTH + 1;
    localparam int PROD_W      = VALUE_WIDTH + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

    // ASCII character output.
    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [3:0] digit_t;
    typedef digit_t [NUM_DIGITS-1:0] digits_t;

    // Contents of one pipeline stage.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] val;   // quotient still to be split up
        digits_t                digs;  // digits found so far, least significant at 0
        logic [CNT_W-1:0]       cnt;   // number of significant digits
        logic                   done;  // cnt is settled
    } stage_t;

endpackage

// ----- hdl/binary_to_decimal_ascii_top.sv -----
// Binary to decimal ASCII converter.
// Input channel: s_valid / s_ready with s_value, an unsigned binary number.
// Output channel: m_valid / m_ready with m_digit_char, one ASCII digit per word,
// most significant first with no leading zeros, and m_last on the final digit.
// A value of zero gives the single word '0' with m_last set.
// The value runs through a pipeline of NUM_DIGITS stages (five for a 16-bit value),
// each of which splits off one decimal digit with a multiply by the reciprocal of ten.
// A final serializer register then sends the digits one word per cycle while m_ready
// is high. An accepted value passes through every stage register before the serializer.
// Throughput: one value per cycle into the pipeline while stage 0 can advance; the
// serializer sends one word per digit, 1 to 5 words per value, and loads the next
// value as the last word of the previous one leaves.
// When the receiver stalls, the serializer holds its word and the pipeline fills up.
// Once the pipeline is full, s_ready drops. No word is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and the serializer.
// No state carries from one value to the next.
`include "binary_to_decimal_ascii_top_assert.svh"

module binary_to_decimal_ascii_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [b2da_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [b2da_pkg::CHAR_W-1:0]      m_digit_char,
    output logic                             m_last
);
    import b2da_pkg::*;

    localparam int N = NUM_DIGITS;

    stage_t             stage_reg  [N];
    stage_t             stage_next [N];
    logic   [N-1:0]     vld_reg;
    logic   [N-1:0]     vld_next;
    logic   [N-1:0]     adv;

    logic   [PROD_W-1:0]      prod [N];
    logic   [VALUE_WIDTH-1:0] quo  [N];
    digit_t                   rem  [N];
    stage_t                   stage_in [N];

    logic                     ser_vld_reg;
    digits_t                  ser_digs_reg;
    logic   [IDX_W-1:0]       ser_idx_reg;
    logic                     ser_ready;
    logic                     ser_final;

    // Serializer takes a new value when empty or when its last word leaves.
    assign ser_final = (ser_idx_reg == '0);
    assign ser_ready = !ser_vld_reg || (m_ready && ser_final);

    // Stage advance: a stage moves when it is empty or the one after it moves.
    always_comb begin
        adv[N-1] = !vld_reg[N-1] || ser_ready;
        for (int i = N - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];

    // Each stage divides its value by ten and stores the remainder as one digit.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                stage_in[i]  = '0;
                stage_in[i].val = s_value;
                vld_next[i]  = s_valid;
            end else begin
                stage_in[i]  = stage_reg[i-1];
                vld_next[i]  = vld_reg[i-1];
            end
            prod[i] = PROD_W'(stage_in[i].val) * PROD_W'(RECIP);
            quo[i]  = VALUE_WIDTH'(prod[i] >> RECIP_SHIFT);
            rem[i]  = stage_in[i].val[3:0] - (4'(quo[i] << 3) + 4'(quo[i] << 1));

            stage_next[i]         = stage_in[i];
            stage_next[i].val     = quo[i];
            stage_next[i].digs[i] = rem[i];
            // The first stage that leaves a zero quotient fixes the digit count.
            if (!stage_in[i].done && (quo[i] == '0)) begin
                stage_next[i].cnt  = CNT_W'(i + 1);
                stage_next[i].done = 1'b1;
            end
        end
    end

    // Pipeline and serializer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            ser_vld_reg <= 1'b0;
        end else begin
            for (int i = 0; i < N; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
            if (ser_ready) begin
                ser_vld_reg <= vld_reg[N-1];
            end
        end
    end

    // Pipeline and serializer payload.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (adv[i]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
        if (ser_ready) begin
            ser_digs_reg <= stage_reg[N-1].digs;
            ser_idx_reg  <= IDX_W'(stage_reg[N-1].cnt - 1'b1);
        end else if (m_ready) begin
            ser_idx_reg  <= ser_idx_reg - 1'b1;
        end
    end

    // Output word: the digit at the current index, most significant first.
    assign m_valid      = ser_vld_reg;
    assign m_digit_char = ASCII_ZERO + {2'b00, ser_digs_reg[ser_idx_reg]};
    assign m_last       = ser_final;

    // Checks on the converter's own logic.
    `B2DA_ASSERT(a_char_range, m_valid,
        (m_digit_char >= ASCII_ZERO) && (m_digit_char <= ASCII_ZERO + 6'd9),
        "output word is not a decimal digit")
    `B2DA_ASSERT(a_count_set, vld_reg[N-1],
        stage_reg[N-1].done && (stage_reg[N-1].cnt != '0),
        "digit count not settled at the end of the pipeline")
    `B2DA_ASSERT_NEXT(a_run_continues, m_valid && m_ready && !m_last,
        m_valid && (ser_idx_reg == $past(ser_idx_reg) - 1'b1),
        "digit run broken before its last word")
    `B2DA_ASSERT_NEXT(a_tail_holds, vld_reg[N-1] && !ser_ready,
        vld_reg[N-1] && $stable(stage_reg[N-1]),
        "final stage changed while the serializer was busy")

endmodule
